[rtl/friction_mass_plant_step_macros.svh]
// Assertion shorthands shared by the files that check their own logic.
// Both forms sample on clk and are switched off while rst is high.
`ifndef FRICTION_MASS_PLANT_STEP_MACROS_SVH
`define FRICTION_MASS_PLANT_STEP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FMPS_ASSERT_IMM(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("fmps assertion failed");
`define FMPS_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("fmps assertion failed");
`else
`define FMPS_ASSERT_IMM(label, cond, prop)
`define FMPS_ASSERT_NXT(label, cond, prop)
`endif
`endif

[rtl/fmps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fmps_pkg;

  // One request: applied force (Q16.16) and time step (Q8.16).
  typedef struct packed {
    logic signed [31:0] applied_force;
    logic [23:0]        time_step;
  } fmps_item_t;

  // One result: new position, velocity and acceleration, and the friction case.
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic               sliding;
  } fmps_result_t;

  // Status of the serial multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // The multiplier operand is at most 31 bits, so every product takes 31 steps.
  localparam int MUL_STEPS = 31;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_STATIC_FRICTION  = 2'd0;
  localparam logic [1:0] REG_KINETIC_FRICTION = 2'd1;
  localparam logic [1:0] REG_INVERSE_MASS     = 2'd2;
  localparam logic [1:0] REG_ZERO_BAND        = 2'd3;

  // Reset values of the registers.
  localparam logic [30:0] STATIC_FRICTION_RST  = 31'd65536;
  localparam logic [30:0] KINETIC_FRICTION_RST = 31'd42598;
  localparam logic [30:0] INVERSE_MASS_RST     = 31'd6554;
  localparam logic [15:0] ZERO_BAND_RST        = 16'd0;

endpackage

`default_nettype wire

[rtl/fmps_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fmps_item_if;
  logic                   valid;
  logic                   ready;
  fmps_pkg::fmps_item_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fmps_result_if;
  logic                   valid;
  logic                   ready;
  fmps_pkg::fmps_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/friction_mass_plant_step.sv]
// A request is worked through as three products formed one after another on
// one shared serial multiplier, followed by a write-back state. A new request
// is accepted only after the previous one is written back, and write-back
// waits while the previous result is still held on the output.
// Reset (rst, synchronous, active high) clears position, velocity and
// acceleration to zero and returns all configuration registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "friction_mass_plant_step_macros.svh"

module friction_mass_plant_step (
  input  logic                  clk,
  input  logic                  rst,
  fmps_item_if.sink             item,
  fmps_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Sequencer states. Each multiply state waits for the serial multiplier and,
  // when it finishes, uses the product and launches the next one, if any.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_MULV = 3'd1;  // previous accel times time step
  localparam logic [2:0] S_MULA = 3'd2;  // force sum times inverse mass
  localparam logic [2:0] S_MULP = 3'd3;  // velocity sum times time step
  localparam logic [2:0] S_WB   = 3'd4;  // update state, load result register

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if ((x[49:31] == '0) || (x[49:31] == '1)) begin
      r = x[31:0];
    end else if (x[49]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [30:0] static_friction_force;
  logic [30:0] kinetic_friction_force;
  logic [30:0] inverse_mass;
  logic [15:0] zero_band;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      static_friction_force  <= fmps_pkg::STATIC_FRICTION_RST;
      kinetic_friction_force <= fmps_pkg::KINETIC_FRICTION_RST;
      inverse_mass           <= fmps_pkg::INVERSE_MASS_RST;
      zero_band              <= fmps_pkg::ZERO_BAND_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        fmps_pkg::REG_STATIC_FRICTION:  static_friction_force  <= pwdata[30:0];
        fmps_pkg::REG_KINETIC_FRICTION: kinetic_friction_force <= pwdata[30:0];
        fmps_pkg::REG_INVERSE_MASS:     inverse_mass           <= pwdata[30:0];
        fmps_pkg::REG_ZERO_BAND:        zero_band              <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fmps_pkg::REG_STATIC_FRICTION:  prdata = {1'b0, static_friction_force};
      fmps_pkg::REG_KINETIC_FRICTION: prdata = {1'b0, kinetic_friction_force};
      fmps_pkg::REG_INVERSE_MASS:     prdata = {1'b0, inverse_mass};
      fmps_pkg::REG_ZERO_BAND:        prdata = {16'd0, zero_band};
      default:                        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Plant state, request capture and sequencer registers
  // ---------------------------------------------------------------------
  logic [2:0]             state;
  logic signed [31:0]     pos_reg;
  logic signed [31:0]     vel_reg;
  logic signed [31:0]     acc_reg;
  logic signed [31:0]     force_r;
  logic [23:0]            dt_r;
  logic signed [31:0]     v_new_r;
  logic signed [31:0]     a_new_r;
  logic signed [31:0]     pos_new_r;
  logic                   res_valid;
  fmps_pkg::fmps_result_t res_r;

  // Shared multiplier.
  logic                   mul_start;
  logic signed [32:0]     mul_md;
  logic [30:0]            mul_mr;
  fmps_pkg::mul_stat_t    mul_stat;
  logic signed [64:0]     product;

  fmps_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .md      (mul_md),
    .mr      (mul_mr),
    .stat    (mul_stat),
    .product (product)
  );

  // ---------------------------------------------------------------------
  // Friction case and operand preparation
  // ---------------------------------------------------------------------
  logic [32:0]        band_ext;
  logic signed [32:0] v_ext;
  logic [32:0]        v_abs;
  logic               vel_pos;
  logic               vel_neg;
  logic               kinetic;
  logic signed [32:0] f_ext;
  logic [32:0]        f_abs;
  logic               force_pos;
  logic signed [32:0] kf_ext;
  logic signed [32:0] fs_ext;
  logic signed [32:0] sum_kin;
  logic signed [32:0] sum_st;
  logic               st_zero;
  logic signed [32:0] acc_md;
  logic signed [31:0] v_sat;
  logic signed [31:0] a_sat;
  logic signed [31:0] p_sat;
  logic               v_new_pos;
  logic               v_new_neg;
  logic               clamp;
  logic signed [31:0] v_fin;
  logic signed [32:0] vsum_md;
  logic               wb_go;
  logic               accept_in;

  always_comb begin
    band_ext = {17'd0, zero_band};

    // The previous velocity stays in vel_reg for the whole request, so the
    // friction case can be derived from it at any point of the sequence.
    v_ext   = {vel_reg[31], vel_reg};
    v_abs   = vel_reg[31] ? 33'(-v_ext) : 33'(v_ext);
    vel_pos = !vel_reg[31] && (vel_reg != '0);
    vel_neg = vel_reg[31];
    kinetic = v_abs > band_ext;

    f_ext     = {force_r[31], force_r};
    f_abs     = force_r[31] ? 33'(-f_ext) : 33'(f_ext);
    force_pos = !force_r[31] && (force_r != '0);

    kf_ext = {2'b00, kinetic_friction_force};
    fs_ext = {2'b00, static_friction_force};

    // Sliding: friction opposes the previous velocity.
    sum_kin = vel_pos ? (f_ext - kf_ext) : (f_ext + kf_ext);

    // At rest: a force that does not overcome static friction leaves the
    // acceleration at zero, which a zero multiplicand produces directly.
    sum_st  = force_pos ? (f_ext - fs_ext) : (f_ext + fs_ext);
    st_zero = force_pos ? sum_st[32] : (!sum_st[32] && (sum_st != '0));
    acc_md  = kinetic ? sum_kin : (st_zero ? '0 : sum_st);

    // Products are floored by taking the upper bits of the exact product.
    v_sat = sat32({{18{vel_reg[31]}}, vel_reg} + {product[64], product[64:16]});
    a_sat = sat32({product[64], product[64:16]});
    p_sat = sat32({{18{pos_reg[31]}}, pos_reg} + {{2{product[64]}}, product[64:17]});

    // A near-zero force while sliding that flips the velocity stops the mass.
    v_new_pos = !v_new_r[31] && (v_new_r != '0);
    v_new_neg = v_new_r[31];
    clamp     = kinetic && (f_abs <= band_ext) &&
                ((v_new_neg && vel_pos) || (v_new_pos && vel_neg));
    v_fin     = clamp ? '0 : v_new_r;
    vsum_md   = v_ext + {v_fin[31], v_fin};
  end

  assign item.ready = (state == S_IDLE);
  assign accept_in  = item.valid && item.ready;
  assign wb_go      = (state == S_WB) && (!res_valid || result.ready);

  // Multiplier launch and operand selection for each step of the sequence.
  always_comb begin
    unique case (state)
      S_IDLE: begin
        mul_start = accept_in;
        mul_md    = {acc_reg[31], acc_reg};
        mul_mr    = {7'd0, item.payload.time_step};
      end
      S_MULV: begin
        mul_start = mul_stat.done;
        mul_md    = acc_md;
        mul_mr    = inverse_mass;
      end
      S_MULA: begin
        mul_start = mul_stat.done;
        mul_md    = vsum_md;
        mul_mr    = {7'd0, dt_r};
      end
      default: begin
        mul_start = 1'b0;
        mul_md    = '0;
        mul_mr    = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer and plant state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos_reg   <= '0;
      vel_reg   <= '0;
      acc_reg   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept_in) begin
            state <= S_MULV;
          end
        end
        S_MULV: begin
          if (mul_stat.done) begin
            state <= S_MULA;
          end
        end
        S_MULA: begin
          if (mul_stat.done) begin
            state <= S_MULP;
          end
        end
        S_MULP: begin
          if (mul_stat.done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (wb_go) begin
            pos_reg   <= pos_new_r;
            vel_reg   <= v_new_r;
            acc_reg   <= a_new_r;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath holding registers; no reset is needed on these.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      force_r <= item.payload.applied_force;
      dt_r    <= item.payload.time_step;
    end
    if ((state == S_MULV) && mul_stat.done) begin
      v_new_r <= v_sat;
    end
    if ((state == S_MULA) && mul_stat.done) begin
      v_new_r <= v_fin;
      a_new_r <= clamp ? '0 : a_sat;
    end
    if ((state == S_MULP) && mul_stat.done) begin
      pos_new_r <= p_sat;
    end
    if (wb_go) begin
      res_r.position <= pos_new_r;
      res_r.speed    <= v_new_r;
      res_r.accel    <= a_new_r;
      res_r.sliding  <= kinetic;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // An accepted request always launches the first product.
  `FMPS_ASSERT_NXT(a_accept_launches_mul, item.valid && item.ready, mul_stat.busy)
  // The sequencer never launches the multiplier while it is still stepping.
  `FMPS_ASSERT_IMM(a_no_launch_while_busy, mul_start, !mul_stat.busy)
  // With zero inverse mass every stored acceleration is zero.
  `FMPS_ASSERT_NXT(a_zero_mass_no_accel, wb_go && (inverse_mass == '0), acc_reg == '0)

endmodule

`default_nettype wire

[rtl/fmps_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add multiplier: signed 33-bit multiplicand times unsigned 31-bit
// multiplier, one multiplier bit per cycle from the least significant end.
module fmps_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [32:0]  md,
  input  logic [30:0]         mr,
  output fmps_pkg::mul_stat_t stat,
  output logic signed [64:0]  product
);

  localparam logic [fmps_pkg::MUL_CNT_W-1:0] LAST_STEP =
    fmps_pkg::MUL_CNT_W'(fmps_pkg::MUL_STEPS - 1);

  logic [fmps_pkg::MUL_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic signed [33:0]             md_r;
  logic signed [33:0]             hi;
  logic [30:0]                    lo;
  logic signed [33:0]             addend;
  logic signed [33:0]             sum;

  // The upper half accumulates; the lower half shifts out multiplier bits and
  // takes in the finished low product bits.
  always_comb begin
    addend = lo[0] ? md_r : '0;
    sum    = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      md_r <= {md[32], md};
      hi   <= '0;
      lo   <= mr;
    end else if (busy) begin
      hi <= {sum[33], sum[33:1]};
      lo <= {sum[0], lo[30:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = {hi, lo};

endmodule

`default_nettype wire

[sim/tb_friction_mass_plant_step.sv]
`timescale 1ns / 1ps

// Self-checking bench for the friction mass plant. Every accepted request is run
// through a local copy of the plant arithmetic, and the predicted state is queued.
// Each result taken from the block is then compared against the oldest entry.
module tb_friction_mass_plant_step;

  localparam int     RESET_CYCLES = 4;
  // Waiting at the end, after the last result, catches any stray result.
  localparam int     DRAIN_CYCLES = 120;
  // About 1.7k requests, each one worst case a long sender gap, the work of the
  // block and a long receiver stall. This limit sits well above that, so it only
  // trips on a hang.
  localparam longint CYCLE_LIMIT  = 3_000_000;
  localparam longint SAT_HI       = 64'sd2147483647;
  localparam longint SAT_LO       = -64'sd2147483648;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fmps_item_if   item_ch ();
  fmps_result_if result_ch ();

  friction_mass_plant_step u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copies of the configuration registers. The masking matches what the
  // block is supposed to do on a write.
  logic [30:0] static_cfg   = fmps_pkg::STATIC_FRICTION_RST;
  logic [30:0] kinetic_cfg  = fmps_pkg::KINETIC_FRICTION_RST;
  logic [30:0] inv_mass_cfg = fmps_pkg::INVERSE_MASS_RST;
  logic [15:0] band_cfg     = fmps_pkg::ZERO_BAND_RST;

  // Predicted plant state. It starts at zero, as the block's reset leaves it.
  logic signed [31:0] pos_st = '0;
  logic signed [31:0] vel_st = '0;
  logic signed [31:0] acc_st = '0;

  // Predicted plant states, in request order, still waiting for their result.
  fmps_pkg::fmps_result_t expected_states[$];

  int     fail_count      = 0;
  int     requests_sent   = 0;
  int     results_checked = 0;
  int     sliding_seen    = 0;
  int     clamps_seen     = 0;
  int     settings_used   = 0;
  int     stall_left      = 0;
  bit     steady          = 1'b0;
  longint cycle_count     = 0;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > SAT_HI) return 32'sh7FFF_FFFF;
    if (x < SAT_LO) return 32'sh8000_0000;
    return 32'(x);
  endfunction

  // Advances the predicted plant by one tick and returns the state the block
  // should report. Every intermediate is a signed 64 bit value. That way the
  // arithmetic right shifts round toward minus infinity, as the block does.
  function automatic fmps_pkg::fmps_result_t plant_advance(input logic signed [31:0] frc,
                                                           input logic [23:0] dt_in);
    longint                 f;
    longint                 dt;
    longint                 band;
    longint                 vp;
    longint                 ap;
    longint                 sum;
    longint                 fric;
    longint                 fstat;
    longint                 inv_m;
    logic signed [31:0]     vn;
    logic signed [31:0]     an;
    bit                     kinetic;
    fmps_pkg::fmps_result_t r;
    f      = longint'(frc);
    dt     = longint'(dt_in);
    band   = longint'(band_cfg);
    fstat  = longint'(static_cfg);
    inv_m  = longint'(inv_mass_cfg);
    vp     = longint'(vel_st);
    ap     = longint'(acc_st);
    kinetic = magnitude(vp) > band;
    // Velocity always moves by the acceleration of the previous tick.
    vn = clip32(vp + ((ap * dt) >>> 16));
    if (kinetic) begin
      // Friction works against the current direction of motion.
      fric = longint'(kinetic_cfg);
      if (vp > 0) fric = -fric;
      an = clip32(((f + fric) * inv_m) >>> 16);
      // With no real force applied, friction may not push the mass back
      // through zero. A strict sign flip stops it dead.
      if (magnitude(f) <= band && ((vn < 0 && vp > 0) || (vn > 0 && vp < 0))) begin
        vn = '0;
        an = '0;
        clamps_seen++;
      end
    end else if (f > 0) begin
      sum = f - fstat;
      an  = (sum < 0) ? 32'sd0 : clip32((sum * inv_m) >>> 16);
    end else begin
      sum = f + fstat;
      an  = (sum > 0) ? 32'sd0 : clip32((sum * inv_m) >>> 16);
    end
    // Trapezoid rule. The extra bit of shift does the halving.
    pos_st = clip32(longint'(pos_st) + (((vp + longint'(vn)) * dt) >>> 17));
    vel_st = vn;
    acc_st = an;
    if (kinetic) sliding_seen++;
    r.position = pos_st;
    r.speed    = vn;
    r.accel    = an;
    r.sliding  = kinetic;
    return r;
  endfunction

  // Idle stretch length: usually a few cycles, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  function automatic int sender_gap();
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return idle_span();
  endfunction

  // Result side back-pressure. ready changes only on the falling edge. While
  // steady is set, results are taken at once.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= idle_span() - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Result checker. It samples on the rising edge at which a result is taken.
  always @(posedge clk) begin : result_check
    fmps_pkg::fmps_result_t want;
    fmps_pkg::fmps_result_t got;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = result_ch.payload;
      if (expected_states.size() == 0) begin
        $error("result with no request outstanding: position %0d", got.position);
        fail_count++;
      end else begin
        want = expected_states.pop_front();
        results_checked++;
        if (got.position !== want.position) begin
          $error("position mismatch: expected %0d, actual %0d", want.position, got.position);
          fail_count++;
        end
        if (got.speed !== want.speed) begin
          $error("speed mismatch: expected %0d, actual %0d", want.speed, got.speed);
          fail_count++;
        end
        if (got.accel !== want.accel) begin
          $error("accel mismatch: expected %0d, actual %0d", want.accel, got.accel);
          fail_count++;
        end
        if (got.sliding !== want.sliding) begin
          $error("sliding mismatch: expected %0d, actual %0d", want.sliding, got.sliding);
          fail_count++;
        end
      end
    end
  end

  // Sends one request and predicts its result once it is accepted. valid stays
  // high into the next request when no gap follows. It is lowered only in the
  // gap, so it is never lowered and raised within one step.
  task automatic send_request(input logic signed [31:0] frc, input logic [23:0] dt);
    fmps_pkg::fmps_item_t req;
    int                   gap;
    req.applied_force = frc;
    req.time_step     = dt;
    @(negedge clk);
    item_ch.valid   <= 1'b1;
    item_ch.payload <= req;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    expected_states.push_back(plant_advance(frc, dt));
    requests_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Holds off the sender until every outstanding request has its result back.
  task automatic wait_all_results();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  // APB write: a setup cycle and then an access cycle. The shadow register takes
  // the masked value at the edge where the write completes.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      fmps_pkg::REG_STATIC_FRICTION:  static_cfg   = value[30:0];
      fmps_pkg::REG_KINETIC_FRICTION: kinetic_cfg  = value[30:0];
      fmps_pkg::REG_INVERSE_MASS:     inv_mass_cfg = value[30:0];
      fmps_pkg::REG_ZERO_BAND:        band_cfg     = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read. The value is compared with the shadow copy in the access cycle.
  task automatic reg_read_check(input logic [1:0] idx);
    logic [31:0] want;
    case (idx)
      fmps_pkg::REG_STATIC_FRICTION:  want = {1'b0, static_cfg};
      fmps_pkg::REG_KINETIC_FRICTION: want = {1'b0, kinetic_cfg};
      fmps_pkg::REG_INVERSE_MASS:     want = {1'b0, inv_mass_cfg};
      default:                        want = {16'd0, band_cfg};
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("prdata mismatch at register %0d: expected %0h, actual %0h", idx, want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes all four registers and reads each one back. Call this only while the
  // block is idle.
  task automatic apply_settings(input logic [31:0] fs, input logic [31:0] fk,
                                input logic [31:0] inv_m, input logic [31:0] band);
    reg_write(fmps_pkg::REG_STATIC_FRICTION, fs);
    reg_write(fmps_pkg::REG_KINETIC_FRICTION, fk);
    reg_write(fmps_pkg::REG_INVERSE_MASS, inv_m);
    reg_write(fmps_pkg::REG_ZERO_BAND, band);
    reg_read_check(fmps_pkg::REG_STATIC_FRICTION);
    reg_read_check(fmps_pkg::REG_KINETIC_FRICTION);
    reg_read_check(fmps_pkg::REG_INVERSE_MASS);
    reg_read_check(fmps_pkg::REG_ZERO_BAND);
    settings_used++;
  endtask

  // A force just above static friction in either direction, clipped to the range.
  function automatic logic signed [31:0] breakaway_force(input bit neg);
    longint mag;
    mag = longint'(static_cfg) + $urandom_range(0, 32'h0008_0000);
    if (mag > SAT_HI) mag = SAT_HI;
    return 32'(neg ? -mag : mag);
  endfunction

  // A force that counts as zero. The band edges themselves come up often.
  function automatic logic signed [31:0] coasting_force();
    longint mag;
    mag = ($urandom_range(0, 3) == 0) ? longint'(band_cfg) : $urandom_range(0, band_cfg);
    return 32'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  function automatic logic [23:0] motion_step();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'h00_0000;
    if (r == 1) return 24'hFF_FFFF;
    return 24'($urandom_range(32'h0000_1000, 32'h0003_0000));
  endfunction

  // One run of random traffic under a fixed register setting. Most of it is a
  // push past static friction followed by a coast at forces that count as zero.
  // That sequence is what reaches the kinetic branch and the sign-change clamp.
  // The rest is raw noise over the full field ranges.
  task automatic random_phase(input int count, input logic [31:0] fs, input logic [31:0] fk,
                              input logic [31:0] inv_m, input logic [31:0] band,
                              input bit quiet);
    int stop_at;
    bit neg;
    int n;
    wait_all_results();
    apply_settings(fs, fk, inv_m, band);
    steady  = quiet;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 49) == 0) wait_all_results();
      if ($urandom_range(0, 9) < 7) begin
        neg = $urandom_range(0, 1);
        n   = $urandom_range(1, 4);
        repeat (n) send_request(breakaway_force(neg), motion_step());
        n = $urandom_range(3, 12);
        repeat (n) send_request(coasting_force(), motion_step());
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          send_request($urandom(), ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
                                   24'($urandom_range(0, 32'h0004_0000)));
        end
      end
    end
    steady = 1'b0;
  endtask

  // Right after reset, every register reads back its default.
  task automatic test_register_defaults();
    reg_read_check(fmps_pkg::REG_STATIC_FRICTION);
    reg_read_check(fmps_pkg::REG_KINETIC_FRICTION);
    reg_read_check(fmps_pkg::REG_INVERSE_MASS);
    reg_read_check(fmps_pkg::REG_ZERO_BAND);
  endtask

  // Register access at the extremes. All-ones writes check that each value is
  // masked to the width of its register.
  task automatic test_register_access();
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    apply_settings(32'h0, 32'h0, 32'h0, 32'h0);
    apply_settings($urandom(), $urandom(), $urandom(), $urandom());
    apply_settings({1'b0, fmps_pkg::STATIC_FRICTION_RST},
                   {1'b0, fmps_pkg::KINETIC_FRICTION_RST},
                   {1'b0, fmps_pkg::INVERSE_MASS_RST},
                   {16'd0, fmps_pkg::ZERO_BAND_RST});
  endtask

  // Hand-picked ticks that go through each branch of the plant update.
  task automatic test_directed_cases();
    // At rest under the defaults. Zero force takes the non-positive branch, and
    // a force exactly equal to static friction, either way, still gives no motion.
    send_request(32'sh0000_0000, 24'h01_0000);
    send_request(32'sh0001_0000, 24'h01_0000);
    send_request(-32'sh0001_0000, 24'h01_0000);
    // Break away forward, then coast. A zero band of zero makes a zero force
    // count as no force.
    send_request(32'sh0005_0000, 24'h01_0000);
    send_request(32'sh0005_0000, 24'h01_0000);
    send_request(32'sh0000_0000, 24'h01_0000);
    send_request(32'sh0000_0000, 24'h00_0000);
    wait_all_results();

    // Strong friction and unit mass with a real zero band. A coast at exactly the
    // band edge should be stopped by the clamp as the mass turns around.
    apply_settings({1'b0, fmps_pkg::STATIC_FRICTION_RST}, 32'h0001_0000, 32'h0001_0000,
                   32'h0000_4000);
    repeat (4) send_request(32'sh0000_4000, 24'h02_0000);
    repeat (2) send_request(-32'sh0005_0000, 24'h02_0000);
    send_request(-32'sh0000_4000, 24'h02_0000);
    repeat (4) send_request(32'sh0000_4000, 24'h02_0000);

    // Extreme force and time step drive every state field into saturation.
    send_request(32'sh7FFF_FFFF, 24'hFF_FFFF);
    send_request(32'sh7FFF_FFFF, 24'hFF_FFFF);
    send_request(32'sh8000_0000, 24'hFF_FFFF);
    send_request(32'sh8000_0000, 24'hFF_FFFF);
    wait_all_results();

    // Zero inverse mass: no force can produce any acceleration.
    apply_settings({1'b0, fmps_pkg::STATIC_FRICTION_RST},
                   {1'b0, fmps_pkg::KINETIC_FRICTION_RST}, 32'h0,
                   {16'd0, fmps_pkg::ZERO_BAND_RST});
    send_request(32'sh7FFF_FFFF, 24'h01_0000);
    send_request(32'sh8000_0000, 24'h01_0000);
    send_request(32'sh1234_5678, 24'h00_8000);
    wait_all_results();

    // Maximum friction with the widest band brakes a saturated mass back to rest.
    // That leaves the random part a usable starting point.
    apply_settings({1'b0, fmps_pkg::STATIC_FRICTION_RST}, 32'h7FFF_FFFF, 32'h0001_0000,
                   32'h0000_FFFF);
    repeat (3) send_request(32'sh0000_0000, 24'h01_8000);
  endtask

  // Random traffic over several register settings: defaults, a lively plant run
  // with no idling, everything zero, everything at its maximum, and random values.
  task automatic test_random_motion();
    random_phase(300, {1'b0, fmps_pkg::STATIC_FRICTION_RST},
                 {1'b0, fmps_pkg::KINETIC_FRICTION_RST},
                 {1'b0, fmps_pkg::INVERSE_MASS_RST},
                 {16'd0, fmps_pkg::ZERO_BAND_RST}, 1'b0);
    random_phase(350, 32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 32'h0000_0400, 1'b1);
    random_phase(150, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    random_phase(100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0);
    random_phase(400, $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                 $urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0000_FFFF), 1'b0);
    random_phase(400, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
  endtask

  initial begin
    // Every input is known from time zero, with reset asserted.
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    result_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_defaults();
    test_register_access();
    test_directed_cases();
    test_random_motion();

    // Let the last results arrive. The extra cycles would expose any result
    // that shows up with no request behind it.
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests under %0d register settings, %0d results checked",
             requests_sent, settings_used, results_checked);
    $display("summary: %0d sliding ticks, %0d sign-change clamps, %0d failures",
             sliding_seen, clamps_seen, fail_count);
    if (fail_count == 0 && expected_states.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
